FILE: sv/phsrp_pkg.sv
package phsrp_pkg;

    // default sizes of the predictor
    localparam int TABLE_ROWS_DEF      = 1024;
    localparam int WEIGHTS_PER_ROW_DEF = 16;
    localparam int HISTORY_DEPTH_DEF   = 5;

    // field widths
    localparam int PC_W       = 48;
    localparam int THR_W      = 9;
    localparam int LIMIT_W    = 5;
    localparam int RRPV_W     = 3;
    localparam int WSUM_W     = 9;
    localparam int WEIGHT_W   = LIMIT_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    // stream packing
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 16;
    localparam int M_PAD_W    = M_TDATA_W - RRPV_W - WSUM_W;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_FRIENDLY_THR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AVERSE_THR    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_LIMIT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRIENDLY_RRPV = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NEUTRAL_RRPV  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_AVERSE_RRPV   = 3'd5;

    // register reset values
    localparam logic signed [THR_W-1:0] FRIENDLY_THR_RST  = 9'sd60;
    localparam logic signed [THR_W-1:0] AVERSE_THR_RST    = 9'sd0;
    localparam logic [LIMIT_W-1:0]      WEIGHT_LIMIT_RST  = 5'd30;
    localparam logic [RRPV_W-1:0]       FRIENDLY_RRPV_RST = 3'd0;
    localparam logic [RRPV_W-1:0]       NEUTRAL_RRPV_RST  = 3'd2;
    localparam logic [RRPV_W-1:0]       AVERSE_RRPV_RST   = 3'd7;

    // controller to datapath commands
    typedef struct packed {
        logic clear_wr;
        logic load;
        logic commit;
    } phsrp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic clear_last;
        logic out_free;
    } phsrp_stat_t;

endpackage

FILE: sv/phsrp_ctrl.sv
module phsrp_ctrl
    import phsrp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  phsrp_stat_t stat,
    output phsrp_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                cmd.load = s_tvalid && ready_reg;
                if (s_tvalid && ready_reg)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.commit = stat.out_free;
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // state and registered ready
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            ready_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= (state_next == ST_IDLE);
        end
    end

    assign s_tready = ready_reg;

endmodule

FILE: sv/phsrp_dpath.sv
module phsrp_dpath
    import phsrp_pkg::*;
#(
    parameter int TABLE_ROWS      = TABLE_ROWS_DEF,
    parameter int WEIGHTS_PER_ROW = WEIGHTS_PER_ROW_DEF,
    parameter int HISTORY_DEPTH   = HISTORY_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  phsrp_cmd_t            cmd,
    output phsrp_stat_t           stat,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int ROW_W  = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1;
    localparam int IDX_W  = $clog2(WEIGHTS_PER_ROW);
    localparam int ROWV_W = WEIGHTS_PER_ROW * WEIGHT_W;
    localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W  = WEIGHT_W + $clog2(HISTORY_DEPTH + 1);
    localparam int CMP_W  = (SUM_W > THR_W) ? SUM_W : THR_W;
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(TABLE_ROWS - 1);

    // configuration registers
    logic signed [THR_W-1:0] friendly_thr_reg;
    logic signed [THR_W-1:0] averse_thr_reg;
    logic [LIMIT_W-1:0]      limit_reg;
    logic [RRPV_W-1:0]       friendly_rrpv_reg;
    logic [RRPV_W-1:0]       neutral_rrpv_reg;
    logic [RRPV_W-1:0]       averse_rrpv_reg;

    // weight memory and access registers
    logic [ROWV_W-1:0] mem [TABLE_ROWS];
    logic [ROWV_W-1:0] rd_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              mode_reg;
    logic [ROW_W-1:0]  clr_cnt_reg;
    logic [ROW_W-1:0]  load_row;
    logic [IDX_W-1:0]  load_idx;

    // pc history
    logic [IDX_W-1:0] hist_reg [HISTORY_DEPTH];
    logic [CNT_W-1:0] hist_cnt_reg;

    // update results
    logic [ROWV_W-1:0]      row_new;
    logic signed [CMP_W-1:0] sum_x;
    logic [RRPV_W-1:0]      rrpv;

    // output register
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    // memory write port
    logic              mem_we;
    logic [ROW_W-1:0]  mem_waddr;
    logic [ROWV_W-1:0] mem_wdata;

    assign load_row = ROW_W'(s_tdata[PC_W-1:0] % TABLE_ROWS);
    assign load_idx = IDX_W'(s_tdata[PC_W-1:0] % WEIGHTS_PER_ROW);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            friendly_thr_reg  <= FRIENDLY_THR_RST;
            averse_thr_reg    <= AVERSE_THR_RST;
            limit_reg         <= WEIGHT_LIMIT_RST;
            friendly_rrpv_reg <= FRIENDLY_RRPV_RST;
            neutral_rrpv_reg  <= NEUTRAL_RRPV_RST;
            averse_rrpv_reg   <= AVERSE_RRPV_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRIENDLY_THR:  friendly_thr_reg  <= $signed(cfg_data[THR_W-1:0]);
                REG_AVERSE_THR:    averse_thr_reg    <= $signed(cfg_data[THR_W-1:0]);
                REG_WEIGHT_LIMIT:  limit_reg         <= cfg_data[LIMIT_W-1:0];
                REG_FRIENDLY_RRPV: friendly_rrpv_reg <= cfg_data[RRPV_W-1:0];
                REG_NEUTRAL_RRPV:  neutral_rrpv_reg  <= cfg_data[RRPV_W-1:0];
                REG_AVERSE_RRPV:   averse_rrpv_reg   <= cfg_data[RRPV_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // clearing pass counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear_wr)
        begin
            clr_cnt_reg <= clr_cnt_reg + ROW_W'(1);
        end
    end

    assign stat.clear_last = (clr_cnt_reg == LAST_ROW);
    assign stat.out_free   = !m_tvalid_reg || m_tready;

    // weight memory, one write and one registered read port
    assign mem_we    = cmd.clear_wr || cmd.commit;
    assign mem_waddr = cmd.clear_wr ? clr_cnt_reg : row_reg;
    assign mem_wdata = cmd.clear_wr ? '0 : row_new;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.load)
        begin
            rd_reg <= mem[load_row];
        end
    end

    // access capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            row_reg  <= load_row;
            idx_reg  <= load_idx;
            mode_reg <= s_tuser;
        end
    end

    // walk the history oldest first, summing and training the row
    always_comb
    begin : walk
        logic [ROWV_W-1:0]         row_v;
        logic signed [SUM_W-1:0]   sum_v;
        logic [IDX_W-1:0]          k;
        logic signed [WEIGHT_W-1:0] w;
        logic signed [WEIGHT_W:0]  wx;
        logic signed [WEIGHT_W:0]  lim;
        row_v = rd_reg;
        sum_v = '0;
        k     = '0;
        w     = '0;
        wx    = '0;
        lim   = $signed({{(WEIGHT_W + 1 - LIMIT_W){1'b0}}, limit_reg});
        for (int i = 0; i < HISTORY_DEPTH; i++)
        begin
            if (CNT_W'(i) < hist_cnt_reg)
            begin
                k     = hist_reg[i];
                w     = $signed(row_v[k * WEIGHT_W +: WEIGHT_W]);
                sum_v = sum_v + SUM_W'(w);
                wx    = (WEIGHT_W + 1)'(w);
                if (mode_reg)
                begin
                    if (wx < lim)
                    begin
                        wx = wx + (WEIGHT_W + 1)'(1);
                    end
                end
                else if (wx > -lim)
                begin
                    wx = wx - (WEIGHT_W + 1)'(1);
                end
                row_v[k * WEIGHT_W +: WEIGHT_W] = wx[WEIGHT_W-1:0];
            end
        end
        row_new = row_v;
        sum_x   = CMP_W'(sum_v);
    end

    // rrpv decision, friendly test first
    always_comb
    begin
        if (sum_x > CMP_W'(friendly_thr_reg))
        begin
            rrpv = friendly_rrpv_reg;
        end
        else if (sum_x < CMP_W'(averse_thr_reg))
        begin
            rrpv = averse_rrpv_reg;
        end
        else
        begin
            rrpv = neutral_rrpv_reg;
        end
    end

    // history update on commit, oldest dropped when full
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HISTORY_DEPTH; i++)
            begin
                hist_reg[i] <= '0;
            end
            hist_cnt_reg <= '0;
        end
        else if (cmd.commit)
        begin
            if (hist_cnt_reg >= CNT_W'(HISTORY_DEPTH))
            begin
                for (int i = 0; i < HISTORY_DEPTH - 1; i++)
                begin
                    hist_reg[i] <= hist_reg[i + 1];
                end
                hist_reg[HISTORY_DEPTH - 1] <= idx_reg;
            end
            else
            begin
                for (int i = 0; i < HISTORY_DEPTH; i++)
                begin
                    if (CNT_W'(i) == hist_cnt_reg)
                    begin
                        hist_reg[i] <= idx_reg;
                    end
                end
                hist_cnt_reg <= hist_cnt_reg + CNT_W'(1);
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            m_tdata_reg <= {{M_PAD_W{1'b0}}, sum_x[WSUM_W-1:0], rrpv};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: sv/pc_history_svm_rrpv_predictor.sv
// order: the row read register loads on the input transfer, and the result register
// loads on the commit that follows, which waits until any stalled result has left
// occupancy: one access at a time (row read, then sum, train and write-back)
// the read-modify-write of one weight row sets the rate: a read, then a write-back
// reset: config registers and pc history return to defaults, weights are zeroed by a
// clearing pass over all TABLE_ROWS rows (1024 by default) during which s_tready stays low
module pc_history_svm_rrpv_predictor
    import phsrp_pkg::*;
#(
    parameter int TABLE_ROWS      = TABLE_ROWS_DEF,
    parameter int WEIGHTS_PER_ROW = WEIGHTS_PER_ROW_DEF,
    parameter int HISTORY_DEPTH   = HISTORY_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [47:0] access_pc
    input  logic                  s_tuser,   // [0] mode
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [2:0] new_rrpv, [11:3] weight_sum, [15:12] zero
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    phsrp_cmd_t  cmd;
    phsrp_stat_t stat;

    // sequencing of clear, load and commit
    phsrp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // weight memory, history and decision
    phsrp_dpath #(
        .TABLE_ROWS      (TABLE_ROWS),
        .WEIGHTS_PER_ROW (WEIGHTS_PER_ROW),
        .HISTORY_DEPTH   (HISTORY_DEPTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

FILE: sv/phsrp_checker.sv
module phsrp_checker
    import phsrp_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // one access at a time: ready drops after an input transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while an access is in flight");

    // a result is on offer after an input transfer, through the row read and result registers
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> ##1 m_tvalid)
        else $error("no result after input transfer");

    // padding bits of the result stay zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[M_TDATA_W-1:RRPV_W+WSUM_W] == '0))
        else $error("result padding not zero");

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind pc_history_svm_rrpv_predictor phsrp_checker u_phsrp_checker (.*);

FILE: tb/rrpv_checker.sv
module rrpv_checker
    import phsrp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [47:0] access_pc
    input  logic                  s_tuser,   // [0] mode
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,   // [2:0] new_rrpv, [11:3] weight_sum, [15:12] zero
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    pending,
    output int                    checked
);

    localparam int PRED_DEPTH = 8;

    // one predicted result per access
    typedef struct packed {
        logic [RRPV_W-1:0] rrpv;
        logic [WSUM_W-1:0] wsum;
    } rrpv_pred_t;

    // predictor state
    int                weights [TABLE_ROWS_DEF][WEIGHTS_PER_ROW_DEF];
    int unsigned       recent_idx [HISTORY_DEPTH_DEF];
    int                recent_n;

    // register copies
    int                friendly_thr;
    int                averse_thr;
    int                limit_mag;
    logic [RRPV_W-1:0] friendly_code;
    logic [RRPV_W-1:0] neutral_code;
    logic [RRPV_W-1:0] averse_code;

    // ring of predictions waiting for their result transfer
    rrpv_pred_t        predicted_buf [PRED_DEPTH];
    int                pred_head;
    int                pred_tail;
    rrpv_pred_t        want;
    int                fail_count;
    int                done_count;

    // walk the pc history, sum and train the row, then pick the insertion rrpv
    function automatic rrpv_pred_t predict_access(input logic [PC_W-1:0] pc, input logic hit);
        int         row;
        int unsigned k;
        int         w;
        int         sum;
        rrpv_pred_t p;
        row = int'(pc % TABLE_ROWS_DEF);
        sum = 0;
        for (int i = 0; i < recent_n; i++)
        begin
            k = recent_idx[i];
            w = weights[row][k];
            sum += w;
            if (hit)
            begin
                if (w < limit_mag)
                    w++;
            end
            else if (w > -limit_mag)
            begin
                w--;
            end
            weights[row][k] = w;
        end
        if (sum > friendly_thr)
            p.rrpv = friendly_code;
        else if (sum < averse_thr)
            p.rrpv = averse_code;
        else
            p.rrpv = neutral_code;
        p.wsum = sum[WSUM_W-1:0];
        // oldest entry drops out once the history is full
        if (recent_n >= HISTORY_DEPTH_DEF)
        begin
            for (int i = 1; i < HISTORY_DEPTH_DEF; i++)
                recent_idx[i-1] = recent_idx[i];
            recent_idx[HISTORY_DEPTH_DEF-1] = int'(pc % WEIGHTS_PER_ROW_DEF);
        end
        else
        begin
            recent_idx[recent_n] = int'(pc % WEIGHTS_PER_ROW_DEF);
            recent_n++;
        end
        return p;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < TABLE_ROWS_DEF; r++)
                for (int c = 0; c < WEIGHTS_PER_ROW_DEF; c++)
                    weights[r][c] = 0;
            for (int i = 0; i < HISTORY_DEPTH_DEF; i++)
                recent_idx[i] = 0;
            recent_n      = 0;
            friendly_thr  = int'(FRIENDLY_THR_RST);
            averse_thr    = int'(AVERSE_THR_RST);
            limit_mag     = int'(WEIGHT_LIMIT_RST);
            friendly_code = FRIENDLY_RRPV_RST;
            neutral_code  = NEUTRAL_RRPV_RST;
            averse_code   = AVERSE_RRPV_RST;
            pred_head     = 0;
            pred_tail     = 0;
            fail_count    = 0;
            done_count    = 0;
            mismatches   <= 0;
            pending      <= 0;
            checked      <= 0;
        end
        else
        begin
            // register writes, unknown indexes are dropped
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_FRIENDLY_THR:  friendly_thr  = int'($signed(cfg_data[THR_W-1:0]));
                    REG_AVERSE_THR:    averse_thr    = int'($signed(cfg_data[THR_W-1:0]));
                    REG_WEIGHT_LIMIT:  limit_mag     = int'(cfg_data[LIMIT_W-1:0]);
                    REG_FRIENDLY_RRPV: friendly_code = cfg_data[RRPV_W-1:0];
                    REG_NEUTRAL_RRPV:  neutral_code  = cfg_data[RRPV_W-1:0];
                    REG_AVERSE_RRPV:   averse_code   = cfg_data[RRPV_W-1:0];
                    default: ;
                endcase
            end

            // access transfer
            if (s_tvalid && s_tready)
            begin
                if (pred_tail - pred_head >= PRED_DEPTH)
                begin
                    $error("access transfer with %0d results outstanding", PRED_DEPTH);
                    fail_count++;
                end
                else
                begin
                    predicted_buf[pred_tail % PRED_DEPTH] =
                        predict_access(s_tdata[PC_W-1:0], s_tuser);
                    pred_tail++;
                end
            end

            // result transfer
            if (m_tvalid && m_tready)
            begin
                if (pred_tail == pred_head)
                begin
                    $error("result transfer with no access waiting: m_tdata=%h", m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = predicted_buf[pred_head % PRED_DEPTH];
                    pred_head++;
                    done_count++;
                    if (m_tdata[RRPV_W-1:0] !== want.rrpv)
                    begin
                        $error("new_rrpv: expected %0d, actual %0d",
                               want.rrpv, m_tdata[RRPV_W-1:0]);
                        fail_count++;
                    end
                    if (m_tdata[RRPV_W+WSUM_W-1:RRPV_W] !== want.wsum)
                    begin
                        $error("weight_sum: expected %0d, actual %0d", $signed(want.wsum),
                               $signed(m_tdata[RRPV_W+WSUM_W-1:RRPV_W]));
                        fail_count++;
                    end
                    if (m_tdata[M_TDATA_W-1:RRPV_W+WSUM_W] !== '0)
                    begin
                        $error("pad: expected 0, actual %h", m_tdata[M_TDATA_W-1:RRPV_W+WSUM_W]);
                        fail_count++;
                    end
                end
            end

            mismatches <= fail_count;
            pending    <= pred_tail - pred_head;
            checked    <= done_count;
        end
    end

endmodule

FILE: tb/testbench.sv
module testbench;
    import phsrp_pkg::*;

    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 160;
    localparam int QUIET_LIMIT = 20000;
    localparam int ROW_BITS    = $clog2(TABLE_ROWS_DEF);
    localparam int IDX_BITS    = $clog2(WEIGHTS_PER_ROW_DEF);

    // indexes that decode to no register
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;   // [47:0] access_pc
    logic                  s_tuser   = 1'b0; // [0] mode
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;          // [2:0] new_rrpv, [11:3] weight_sum, [15:12] zero
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int mismatches;
    int pending;
    int checked;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int accesses_sent  = 0;
    int quiet_cycles   = 0;
    int hit_pct        = 50;
    int burst_left     = 0;

    logic [ROW_BITS-IDX_BITS-1:0] hot_hi  [2];
    logic [IDX_BITS-1:0]          hot_idx [3];

    always #1 clk = ~clk;

    pc_history_svm_rrpv_predictor u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rrpv_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending),
        .checked    (checked)
    );

    // result side back-pressure
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog on cycles with no transfer and no register write
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // present one access and hold it until the transfer
    task automatic send_access(input logic [PC_W-1:0] pc, input logic hit);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pc;
        s_tuser  <= hit;
        do
            @(posedge clk);
        while (!s_tready);
        accesses_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        @(posedge clk);
    endtask

    // stop sending and wait for every predicted result
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // register set for each phase, with junk in the unused upper data bits
    task automatic apply_setting(input int phase);
        int fthr;
        int athr;
        int lim;
        int fr;
        int nr;
        int ar;
        case (phase)
            1: begin fthr = -256; athr = -256; lim = 31; fr = 7; nr = 0; ar = 3; end
            2: begin fthr = 255;  athr = 255;  lim = 1;  fr = 1; nr = 4; ar = 6; end
            3: begin fthr = 0;    athr = 0;    lim = 0;  fr = 2; nr = 5; ar = 0; end
            4: begin fthr = 100;  athr = -100; lim = 15; fr = 3; nr = 6; ar = 1; end
            5: begin fthr = 150;  athr = -150; lim = 31; fr = 0; nr = 2; ar = 7; end
            6: begin fthr = -150; athr = 150;  lim = 8;  fr = 5; nr = 3; ar = 4; end
            default:
            begin
                fthr = int'($urandom_range(300)) - 150;
                athr = int'($urandom_range(300)) - 150;
                lim  = $urandom_range(31, 1);
                fr   = $urandom_range(7);
                nr   = $urandom_range(7);
                ar   = $urandom_range(7);
            end
        endcase
        write_reg(REG_FRIENDLY_THR, fthr);
        write_reg(REG_AVERSE_THR, athr);
        write_reg(REG_WEIGHT_LIMIT, lim | ($urandom_range(15) << LIMIT_W));
        write_reg(REG_FRIENDLY_RRPV, fr | ($urandom_range(63) << RRPV_W));
        write_reg(REG_NEUTRAL_RRPV, nr | ($urandom_range(63) << RRPV_W));
        write_reg(REG_AVERSE_RRPV, ar | ($urandom_range(63) << RRPV_W));
        // writes to unused indexes must change nothing
        if (phase == 3)
        begin
            write_reg(REG_UNUSED_LO, $urandom_range(511));
            write_reg(REG_UNUSED_HI, $urandom_range(511));
        end
        cfg_we <= 1'b0;
    endtask

    // mostly a few hot rows so weights saturate, in hit-heavy, balanced or miss-heavy bursts
    task automatic random_access();
        logic [PC_W-1:0] pc;
        logic            hit;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(40, 10);
            case ($urandom_range(2))
                0:       hit_pct = 5;
                1:       hit_pct = 50;
                default: hit_pct = 95;
            endcase
        end
        burst_left--;
        pc = PC_W'({$urandom, $urandom});
        if ($urandom_range(99) >= 10)
            pc[ROW_BITS-1:0] = {hot_hi[$urandom_range(1)], hot_idx[$urandom_range(2)]};
        hit = ($urandom_range(99) < hit_pct);
        send_access(pc, hit);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // empty history, pc extremes, one row hammered until saturation and back
        send_access('0, 1'b0);
        repeat (11) send_access('1, 1'b1);
        repeat (10) send_access('1, 1'b0);
        send_access(48'h5555_5555_5555, 1'b1);
        send_access(48'hAAAA_AAAA_AAAA, 1'b0);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase != 0)
            begin
                wait_idle();
                apply_setting(phase);
            end
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
                default: begin send_idle_pct = 11; recv_stall_pct = 11; end
            endcase
            foreach (hot_hi[i])
                hot_hi[i] = (ROW_BITS - IDX_BITS)'($urandom);
            foreach (hot_idx[i])
                hot_idx[i] = IDX_BITS'($urandom);
            repeat (PHASE_ITEMS) random_access();
        end

        wait_idle();
        repeat (4) @(posedge clk);

        $display("covered %0d accesses over %0d register settings and four idle mixes",
                 accesses_sent, PHASES);
        $display("%0d rrpv predictions compared, %0d mismatches", checked, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: filelist.f
sv/phsrp_pkg.sv
sv/phsrp_ctrl.sv
sv/phsrp_dpath.sv
sv/pc_history_svm_rrpv_predictor.sv
sv/phsrp_checker.sv
tb/rrpv_checker.sv
tb/testbench.sv
